// ===== src/crcbl_pkg.sv =====
// Shared types, constants and constant functions for the CRC-32C byte-lane block.
// No dependencies; every other file imports this package.
package crcbl_pkg;

  localparam int BytesPerItem = 8;
  localparam int LaneCount    = (BytesPerItem < 8) ? BytesPerItem : 8;
  localparam int CntW         = $clog2(LaneCount + 1);
  localparam int DataW        = 64;
  localparam int CountW       = 4;
  localparam int CrcW         = 32;

  localparam logic [CrcW-1:0] CrcPoly   = 32'h82F6_3B78;
  localparam logic [CrcW-1:0] CrcInvert = 32'hFFFF_FFFF;

  typedef logic [CrcW-1:0] crc_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef crc_t [7:0]                  lane_mat_t;
  typedef lane_mat_t [LaneCount-1:0]   lane_mats_t;
  typedef crc_t [CrcW-1:0]             adv_mat_t;
  typedef adv_mat_t [LaneCount:0]      adv_mats_t;

  typedef struct packed {
    crc_t [LaneCount-1:0] lane_crc;
    cnt_t                 nbytes;
    logic                 first;
    logic                 last;
    crc_t                 start;
  } beat_t;

  function automatic crc_t shift_bits(crc_t c, int nbits);
    crc_t v;
    v = c;
    for (int i = 0; i < nbits; i++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

  function automatic lane_mats_t build_lane_mats();
    lane_mats_t m;
    for (int j = 0; j < LaneCount; j++) begin
      for (int k = 0; k < 8; k++) begin
        m[j][k] = shift_bits(crc_t'(1) << k, 8 * (LaneCount - j));
      end
    end
    return m;
  endfunction

  function automatic adv_mats_t build_adv_mats();
    adv_mats_t m;
    for (int n = 0; n <= LaneCount; n++) begin
      for (int k = 0; k < CrcW; k++) begin
        m[n][k] = shift_bits(crc_t'(1) << k, 8 * n);
      end
    end
    return m;
  endfunction

  localparam lane_mats_t LaneMats = build_lane_mats();
  localparam adv_mats_t  AdvMats  = build_adv_mats();

endpackage

// ===== src/crcbl_lane.sv =====
// One byte lane: folds a single aligned byte through its fixed GF(2) matrix.
// Depends on crcbl_pkg for the CRC and matrix types.
module crcbl_lane
  import crcbl_pkg::*;
(
  input  logic [7:0] byte_i,
  input  lane_mat_t  mat_i,
  output crc_t       crc_o
);

  always_comb begin
    crc_o = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte_i[k]) begin
        crc_o = crc_o ^ mat_i[k];
      end
    end
  end

endmodule

// ===== src/crcbl_merge.sv =====
// Merge stage: combines the lane results with the advanced running CRC and holds message state.
// Depends on crcbl_pkg for the beat struct and the advance matrices.
module crcbl_merge
  import crcbl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  move_i,
  input  beat_t beat_i,
  output crc_t  result_o
);

  crc_t running_q, running_d;
  crc_t saved_q, saved_d;
  logic seen_q, seen_d;
  crc_t state_in;
  crc_t advanced;
  crc_t lanes_sum;
  adv_mat_t adv_mat;

  assign state_in = beat_i.first ? (beat_i.start ^ CrcInvert) : running_q;
  assign adv_mat  = AdvMats[beat_i.nbytes];

  always_comb begin
    advanced  = '0;
    lanes_sum = '0;
    for (int k = 0; k < CrcW; k++) begin
      if (state_in[k]) begin
        advanced = advanced ^ adv_mat[k];
      end
    end
    for (int j = 0; j < LaneCount; j++) begin
      lanes_sum = lanes_sum ^ beat_i.lane_crc[j];
    end
  end

  assign running_d = advanced ^ lanes_sum;
  assign saved_d   = beat_i.first ? beat_i.start : saved_q;
  assign seen_d    = (beat_i.first ? 1'b0 : seen_q) | (beat_i.nbytes != '0);
  assign result_o  = seen_d ? (running_d ^ CrcInvert) : saved_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      saved_q   <= '0;
      seen_q    <= 1'b0;
    end else if (move_i) begin
      running_q <= running_d;
      saved_q   <= saved_d;
      seen_q    <= seen_d;
    end
  end

endmodule

// ===== src/crc32c_byte_lanes.sv =====
// Top level of the reflected CRC-32C engine with parallel byte lanes.
// Depends on crcbl_pkg, crcbl_lane and crcbl_merge.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | data, byte_count, first, last, start_crc
//   out     | output    | out_valid_o / out_stall_i | crc
//
// One beat is taken each clock unless stalled; a result passes the lane and output registers.
// The running CRC loop closes in the merge stage through one advance matrix and an XOR tree.
// Reset clears the pipeline valids and the message state to zero.
// A stalled result holds the output register, and the lane stage keeps taking beats until a
// last beat waits in it.
module crc32c_byte_lanes
  import crcbl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DataW-1:0]  in_data_i,
  input  logic [CountW-1:0] in_byte_count_i,
  input  logic              in_first_i,
  input  logic              in_last_i,
  input  logic [CrcW-1:0]   in_start_crc_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CrcW-1:0]   out_crc_o
);

  logic in_accept, s1_move, out_free;
  logic s1_valid_q, s1_valid_d;
  beat_t beat_q, beat_d;
  logic out_valid_q, out_valid_d;
  crc_t out_crc_q;
  crc_t merge_result;
  cnt_t nbytes;
  cnt_t shift_bytes;
  logic [8*LaneCount-1:0] window;
  logic [8*LaneCount-1:0] aligned;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && (!beat_q.last || out_free);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign nbytes = (in_byte_count_i > CountW'(LaneCount)) ? cnt_t'(LaneCount)
                                                         : in_byte_count_i[CntW-1:0];
  assign shift_bytes = cnt_t'(LaneCount) - nbytes;
  assign window      = in_data_i[8*LaneCount-1:0];
  assign aligned     = window << {shift_bytes, 3'b000};

  for (genvar j = 0; j < LaneCount; j++) begin : g_lane
    crcbl_lane u_lane (
      .byte_i (aligned[8*j +: 8]),
      .mat_i  (LaneMats[j]),
      .crc_o  (beat_d.lane_crc[j])
    );
  end

  assign beat_d.nbytes = nbytes;
  assign beat_d.first  = in_first_i;
  assign beat_d.last   = in_last_i;
  assign beat_d.start  = in_start_crc_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_move && beat_q.last) begin
      out_valid_d = 1'b1;
    end
  end

  crcbl_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .move_i   (s1_move),
    .beat_i   (beat_q),
    .result_o (merge_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      beat_q <= beat_d;
    end
    if (s1_move && beat_q.last) begin
      out_crc_q <= merge_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_crc_o   = out_crc_q;

endmodule

// ===== src/crcbl_checker.sv =====
// Port-level checks for the CRC-32C byte-lane block, attached to the top level by bind.
// Depends on crcbl_pkg for the CRC width.
module crcbl_checker
  import crcbl_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_i,
  input logic            out_valid_i,
  input logic            out_stall_i,
  input logic [CrcW-1:0] out_crc_i
);

  // The input side only backs up when a result is held by the receiver.
  a_stall_needs_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || !out_stall_i) |-> !in_stall_i)
    else $error("input stalled while the output register was free");

  a_stall_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |=> out_valid_i)
    else $error("held result vanished after an input stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_stall_i) |=> (out_valid_i && $stable(out_crc_i)))
    else $error("stalled output beat changed");

endmodule

bind crc32c_byte_lanes crcbl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_crc_i   (out_crc_o)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for crc32c_byte_lanes: drives random and directed messages of
// byte-lane beats, predicts each reflected CRC-32C result and compares it at the output.
// Depends on crcbl_pkg and the crc32c_byte_lanes RTL.
module tb_top;
  import crcbl_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [DataW-1:0]  in_data_i = '0;
  logic [CountW-1:0] in_byte_count_i = '0;
  logic              in_first_i = 1'b0;
  logic              in_last_i = 1'b0;
  logic [CrcW-1:0]   in_start_crc_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CrcW-1:0]   out_crc_o;

  int   sender_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   err_count = 0;
  crc_t crc_expected_q[$];

  crc_t crc_work = '0;
  logic msg_seen_byte = 1'b0;
  crc_t msg_start = '0;

  crc32c_byte_lanes i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .in_byte_count_i (in_byte_count_i),
    .in_first_i      (in_first_i),
    .in_last_i       (in_last_i),
    .in_start_crc_i  (in_start_crc_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_crc_o       (out_crc_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic crc_t crc_fold_byte(crc_t c, logic [7:0] b);
    crc_t v;
    v = c ^ crc_t'(b);
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

  task automatic predict_crc_beat(input logic [DataW-1:0] d, input logic [CountW-1:0] n,
                                  input logic f, input logic l, input crc_t s);
    int lanes;
    lanes = int'(n);
    if (f) begin
      msg_start = s;
      crc_work = s ^ CrcInvert;
      msg_seen_byte = 1'b0;
    end
    if (lanes > LaneCount) begin
      lanes = LaneCount;
    end
    for (int i = 0; i < lanes; i++) begin
      crc_work = crc_fold_byte(crc_work, d[8*i +: 8]);
    end
    if (lanes != 0) begin
      msg_seen_byte = 1'b1;
    end
    if (l) begin
      crc_expected_q.push_back(msg_seen_byte ? (crc_work ^ CrcInvert) : msg_start);
    end
  endtask

  task automatic send_beat(input logic [DataW-1:0] d, input logic [CountW-1:0] n,
                           input logic f, input logic l, input crc_t s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      in_data_i = {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_data_i = d;
    in_byte_count_i = n;
    in_first_i = f;
    in_last_i = l;
    in_start_crc_i = s;
    in_valid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_crc_beat(d, n, f, l, s);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    crc_t exp_crc;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (crc_expected_q.size() == 0) begin
        $error("crc: expected none, actual %h", out_crc_o);
        err_count++;
      end else begin
        exp_crc = crc_expected_q.pop_front();
        if (out_crc_o !== exp_crc) begin
          $error("crc: expected %h, actual %h", exp_crc, out_crc_o);
          err_count++;
        end
      end
    end
  end

  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 22) return CountW'(8);
    if (r < 27) return CountW'($urandom_range(9, 15));
    return CountW'($urandom_range(1, 7));
  endfunction

  function automatic crc_t pick_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return CrcInvert;
    return crc_t'($urandom);
  endfunction

  task automatic run_random_messages(input int n_beats);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 6);
      if (kind < 85) begin
        for (int k = 0; k < len; k++) begin
          send_beat({$urandom, $urandom}, pick_count(), k == 0, k == len - 1, pick_start());
        end
        sent += len;
      end else if (kind < 93) begin
        send_beat({$urandom, $urandom}, CountW'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), pick_start());
        sent++;
      end else begin
        for (int k = 0; k < len; k++) begin
          send_beat({$urandom, $urandom}, pick_count(), k == 0, 1'b0, pick_start());
        end
        sent += len;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_beat({$urandom, $urandom}, 4'd3, 1'b0, 1'b1, 32'h0);
    send_beat({$urandom, $urandom}, 4'd0, 1'b0, 1'b1, 32'h0);
    send_beat('0, 4'd0, 1'b1, 1'b1, 32'h1234_5678);
    send_beat('1, 4'd0, 1'b1, 1'b1, CrcInvert);
    send_beat('0, 4'd8, 1'b1, 1'b1, 32'h0);
    send_beat('1, 4'd8, 1'b1, 1'b1, CrcInvert);
    send_beat(64'hFF, 4'd1, 1'b1, 1'b1, 32'h0);
    send_beat({$urandom, $urandom}, 4'd15, 1'b1, 1'b1, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd9, 1'b1, 1'b1, crc_t'($urandom));
    send_beat('1, 4'd0, 1'b1, 1'b0, 32'hDEAD_BEEF);
    send_beat('1, 4'd0, 1'b0, 1'b0, 32'h0);
    send_beat('1, 4'd0, 1'b0, 1'b1, 32'h0);
    send_beat({$urandom, $urandom}, 4'd0, 1'b1, 1'b0, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd5, 1'b0, 1'b0, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd0, 1'b0, 1'b1, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd2, 1'b0, 1'b1, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd4, 1'b1, 1'b0, crc_t'($urandom));
    send_beat({$urandom, $urandom}, 4'd8, 1'b1, 1'b1, crc_t'($urandom));
    send_beat(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 32'h0);
    send_beat(64'h39, 4'd1, 1'b0, 1'b1, 32'h0);
  endtask

  task automatic test_steady_stream();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_messages(360);
  endtask

  task automatic test_sparse_sender();
    sender_idle_pct = 84;
    recv_stall_pct = 0;
    run_random_messages(360);
  endtask

  task automatic test_slow_receiver();
    sender_idle_pct = 0;
    recv_stall_pct = 84;
    run_random_messages(360);
  endtask

  task automatic test_mixed_idle();
    sender_idle_pct = 31;
    recv_stall_pct = 31;
    run_random_messages(360);
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_steady_stream();
    test_sparse_sender();
    test_slow_receiver();
    test_mixed_idle();
    guard = 0;
    while (crc_expected_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (crc_expected_q.size() != 0) begin
      $error("crc: expected %0d more beats, actual none", crc_expected_q.size());
      err_count++;
    end
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
